@@ design/kcc_pkg.sv @@
// Package for the monochromatic four-clique counter.
// Holds sizes, mode codes, the memory request type and the row helper functions.
// No dependencies.
package kcc_pkg;

	localparam int VERTICES = 128;
	localparam int V_BITS   = 7;
	localparam int CTR_BITS = V_BITS + 1;
	localparam int ROW_W    = 128;
	localparam int CNT_W    = 24;
	localparam int PC_W     = 8;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_ALL   = 2'd1;
	localparam logic [1:0] MODE_PAIR  = 2'd2;

	localparam logic [CTR_BITS-1:0] V_LAST = CTR_BITS'(VERTICES);

	typedef struct packed {
		logic              rd_en;
		logic [V_BITS-1:0] rd_addr;
		logic              wr_en;
		logic [V_BITS-1:0] wr_addr;
	} mem_req_t;

	// Bits whose vertex index is strictly above k.
	function automatic logic [ROW_W-1:0] above_mask(input logic [V_BITS-1:0] k);
		logic [ROW_W-1:0] m;
		for (int b = 0; b < ROW_W; b++) begin
			m[b] = (b > int'(k)) && (b < VERTICES);
		end
		return m;
	endfunction

	// Neighborhood in the requested color, limited to existing vertices.
	function automatic logic [ROW_W-1:0] nbr(input logic [ROW_W-1:0] row, input logic c);
		logic [ROW_W-1:0] m;
		for (int b = 0; b < ROW_W; b++) begin
			m[b] = (b < VERTICES);
		end
		return (c ? row : ~row) & m;
	endfunction

	function automatic logic [PC_W-1:0] popcount(input logic [ROW_W-1:0] x);
		logic [PC_W-1:0] n;
		n = '0;
		for (int b = 0; b < ROW_W; b++) begin
			n = n + PC_W'(x[b]);
		end
		return n;
	endfunction

endpackage

@@ design/mono_k4_clique_counter_unit.sv @@
// Monochromatic four-clique counter over a two-colored complete graph on 128 vertices.
// Edge write: both rows are read and written back. Pair count: a 128-step scan
// of the common neighborhood. Full count: a scan over every pair in the color,
// one candidate third vertex per cycle through the row memory read port.
// One item is worked at a time; a finished result waits in the output register.
// Reset clears all edges to color 0 via per-row valid bits, with no clearing pass.
module mono_k4_clique_counter_unit import kcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [V_BITS-1:0] vertex_a,
	input  logic [V_BITS-1:0] vertex_b,
	input  logic              color,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CNT_W-1:0]  clique_count,
	output logic [1:0]        answered_mode
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_WR_A   = 15'b000000000000010,
		ST_WR_B   = 15'b000000000000100,
		ST_WR_C   = 15'b000000000001000,
		ST_ALL_I  = 15'b000000000010000,
		ST_ALL_IW = 15'b000000000100000,
		ST_ALL_J  = 15'b000000001000000,
		ST_ALL_JW = 15'b000000010000000,
		ST_ALL_K  = 15'b000000100000000,
		ST_PR_A   = 15'b000001000000000,
		ST_PR_B   = 15'b000010000000000,
		ST_PR_S   = 15'b000100000000000,
		ST_PR_K   = 15'b001000000000000,
		ST_DRAIN  = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} state_t;

	state_t state_q;

	// The item being worked on, latched at the input transfer.
	logic [1:0]        mode_q;
	logic [V_BITS-1:0] a_q;
	logic [V_BITS-1:0] b_q;
	logic              c_q;

	// Loop counters, one bit wider than a vertex index so they can reach the end.
	logic [CTR_BITS-1:0] i_q;
	logic [CTR_BITS-1:0] j_q;
	logic [CTR_BITS-1:0] k_q;

	// Row registers: in the full count the neighborhoods of i and j; in the pair
	// count ri_q holds the common neighborhood of the pair and rj_q is all ones.
	logic [ROW_W-1:0] ri_q;
	logic [ROW_W-1:0] rj_q;

	// Counting pipeline: s1 marks a third-vertex read in flight, s2 holds the
	// masked intersection whose population count goes into the accumulator.
	logic              kv_s1;
	logic [V_BITS-1:0] k_s1;
	logic              v_s2;
	logic [ROW_W-1:0]  and_s2;
	logic [CNT_W-1:0]  acc_q;

	logic              out_valid_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        amode_q;

	mem_req_t          req;
	logic [ROW_W-1:0]  wr_data;
	logic [ROW_W-1:0]  rd_data;
	logic [ROW_W-1:0]  rd_nbr;
	logic [ROW_W-1:0]  common_nbr;
	logic              in_xfer;
	logic              issue_k;
	logic              out_free;

	kcc_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign rd_nbr   = nbr(rd_data, c_q);
	assign out_free = !out_valid_q || !out_stall;

	// Common neighborhood of the pair, with the two given vertices taken out.
	always_comb begin
		common_nbr      = ri_q & rd_nbr;
		common_nbr[a_q] = 1'b0;
		common_nbr[b_q] = 1'b0;
	end

	// A third vertex is read only when it closes a triangle with the current
	// pair (full count) or lies in the common neighborhood (pair count).
	always_comb begin
		issue_k = 1'b0;
		if ((state_q == ST_ALL_K || state_q == ST_PR_K) && k_q != V_LAST) begin
			issue_k = ri_q[k_q[V_BITS-1:0]] && rj_q[k_q[V_BITS-1:0]];
		end
	end

	// Memory requests. Writes happen only in the edge update; the second row is
	// read while the first is written back, and the two rows always differ.
	always_comb begin
		req         = '0;
		wr_data     = rd_data;
		unique case (state_q)
			ST_WR_A: begin
				req.rd_en   = 1'b1;
				req.rd_addr = a_q;
			end
			ST_WR_B: begin
				req.wr_en   = 1'b1;
				req.wr_addr = a_q;
				wr_data[b_q] = c_q;
				req.rd_en   = 1'b1;
				req.rd_addr = b_q;
			end
			ST_WR_C: begin
				req.wr_en   = 1'b1;
				req.wr_addr = b_q;
				wr_data[a_q] = c_q;
			end
			ST_ALL_I: begin
				req.rd_en   = 1'b1;
				req.rd_addr = i_q[V_BITS-1:0];
			end
			ST_ALL_J: begin
				req.rd_en   = (j_q != V_LAST) && ri_q[j_q[V_BITS-1:0]];
				req.rd_addr = j_q[V_BITS-1:0];
			end
			ST_ALL_K, ST_PR_K: begin
				req.rd_en   = issue_k;
				req.rd_addr = k_q[V_BITS-1:0];
			end
			ST_PR_A: begin
				req.rd_en   = 1'b1;
				req.rd_addr = a_q;
			end
			ST_PR_B: begin
				req.rd_en   = 1'b1;
				req.rd_addr = b_q;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode;
			a_q    <= vertex_a;
			b_q    <= vertex_b;
			c_q    <= color;
		end
		k_s1   <= k_q[V_BITS-1:0];
		and_s2 <= ri_q & rj_q & rd_nbr & above_mask(k_s1);
		unique case (state_q)
			ST_ALL_IW: begin
				ri_q <= rd_nbr;
			end
			ST_ALL_JW: begin
				rj_q <= rd_nbr;
			end
			ST_PR_B: begin
				ri_q <= rd_nbr;
			end
			ST_PR_S: begin
				ri_q <= common_nbr;
				rj_q <= '1;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			count_q <= (mode_q == MODE_ALL || mode_q == MODE_PAIR) ? acc_q : '0;
			amode_q <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			kv_s1       <= 1'b0;
			v_s2        <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			kv_s1 <= issue_k;
			v_s2  <= kv_s1;
			if (in_xfer) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + CNT_W'(popcount(and_s2));
			end
			// A result leaves at its transfer and a new one is loaded when the
			// register is free.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						i_q <= '0;
						k_q <= '0;
						priority if (mode == MODE_WRITE && vertex_a != vertex_b) begin
							state_q <= ST_WR_A;
						end else if (mode == MODE_ALL) begin
							state_q <= ST_ALL_I;
						end else if (mode == MODE_PAIR) begin
							state_q <= ST_PR_A;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WR_A:   state_q <= ST_WR_B;
				ST_WR_B:   state_q <= ST_WR_C;
				ST_WR_C:   state_q <= ST_DONE;
				ST_ALL_I:  state_q <= ST_ALL_IW;
				ST_ALL_IW: begin
					j_q     <= i_q + 1'b1;
					state_q <= ST_ALL_J;
				end
				ST_ALL_J: begin
					if (j_q == V_LAST) begin
						i_q     <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 == V_LAST) ? ST_DRAIN : ST_ALL_I;
					end else if (ri_q[j_q[V_BITS-1:0]]) begin
						state_q <= ST_ALL_JW;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_ALL_JW: begin
					k_q     <= j_q + 1'b1;
					state_q <= ST_ALL_K;
				end
				ST_ALL_K: begin
					if (k_q == V_LAST) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_ALL_J;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_PR_A:   state_q <= ST_PR_B;
				ST_PR_B:   state_q <= ST_PR_S;
				ST_PR_S: begin
					k_q     <= '0;
					state_q <= ST_PR_K;
				end
				ST_PR_K: begin
					if (k_q == V_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!kv_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign clique_count  = count_q;
	assign answered_mode = amode_q;

	// A new result is loaded only on leaving the final state.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the final state");

	// The result is never presented while counting reads are still in flight.
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!kv_s1 && !v_s2))
		else $error("result stage reached with counting pipeline busy");

	// Memory writes belong to the edge update only.
	a_write_only_edge: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> (state_q == ST_WR_B || state_q == ST_WR_C))
		else $error("row write outside an edge update");

	// The accumulator only moves while an item is being worked on.
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !in_valid) |=> $stable(acc_q))
		else $error("accumulator changed while idle");

endmodule

@@ design/kcc_row_mem.sv @@
// Adjacency row memory: one row of vertex bits per vertex, registered read.
// A per-row valid bit makes rows that were never written read as all zeros.
// Depends on kcc_pkg.
module kcc_row_mem import kcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_req_t         req,
	input  logic [ROW_W-1:0] wr_data,
	output logic [ROW_W-1:0] rd_data
);

	logic [ROW_W-1:0] mem [VERTICES];
	logic [VERTICES-1:0] row_valid_q;
	logic [ROW_W-1:0] data_q;
	logic             data_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			data_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				data_valid_q <= row_valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = data_valid_q ? data_q : '0;

endmodule

@@ sim/mono_k4_clique_counter_unit_tb.sv @@
// Self-checking testbench for mono_k4_clique_counter_unit: a directed table, then random
// edge writes, pair queries and mode 3 items, checked against a behavioral
// clique predictor. Depends on kcc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module mono_k4_clique_counter_unit_tb;
	import kcc_pkg::*;

	// Mode 3 is not decoded by the block; it just echoes a zero count.
	localparam logic [1:0] MODE_NONE = 2'd3;

	// A full count runs long without any transfer, so the limit on cycles without
	// any transfer is set well above its length, with stalls on top.
	localparam int IDLE_LIMIT   = 2000000;
	localparam int N_RANDOM     = 85;
	localparam int CALM_TAIL    = 15;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [CNT_W-1:0] count;
		logic [1:0]       mode;
	} answer_t;

	// A directed row; the answer is typed in only where it is obvious.
	typedef struct {
		logic [1:0]        mode;
		logic [V_BITS-1:0] a;
		logic [V_BITS-1:0] b;
		logic              c;
		bit                known;
		logic [CNT_W-1:0]  count;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        mode;
	logic [V_BITS-1:0] vertex_a;
	logic [V_BITS-1:0] vertex_b;
	logic              color;
	logic              out_valid;
	logic              out_stall;
	logic [CNT_W-1:0]  clique_count;
	logic [1:0]        answered_mode;

	mono_k4_clique_counter_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.color        (color),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.clique_count (clique_count),
		.answered_mode(answered_mode)
	);

	// Predictor state: the full VERTICES x ROW_W edge-color matrix, a set bit meaning color 1.
	logic [ROW_W-1:0] edge_rows [VERTICES];

	answer_t pending_answers[$];
	row_t    typed_rows[$];
	int      errors;
	int      answers_seen;
	bit      calm;
	bit      sender_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Neighborhood of v in color c.
	function automatic logic [ROW_W-1:0] hood(input int v, input logic c);
		return c ? edge_rows[v] : ~edge_rows[v];
	endfunction

	// Bits of vertices strictly above k.
	function automatic logic [ROW_W-1:0] higher(input int k);
		logic [ROW_W-1:0] m;
		m = '1;
		return m << (k + 1);
	endfunction

	// Works out the answer to one item and applies edge writes to the matrix.
	function automatic answer_t predict_clique_answer(input logic [1:0] m,
			input int a, input int b, input logic c);
		answer_t          r;
		logic [ROW_W-1:0] common;
		int unsigned      total;
		total = 0;
		case (m)
			MODE_WRITE: begin
				// A self loop is dropped; the diagonal is never counted.
				if (a != b) begin
					edge_rows[a][b] = c;
					edge_rows[b][a] = c;
				end
			end
			MODE_ALL: begin
				for (int i = 0; i < VERTICES; i++)
					for (int j = i + 1; j < VERTICES; j++) begin
						if (!hood(i, c)[j]) continue;
						for (int k = j + 1; k < VERTICES; k++) begin
							if (!hood(i, c)[k] || !hood(j, c)[k]) continue;
							total += $countones(hood(i, c) & hood(j, c) & hood(k, c)
								& higher(k));
						end
					end
			end
			MODE_PAIR: begin
				// The a-b edge itself is never looked at.
				common = hood(a, c) & hood(b, c);
				common[a] = 1'b0;
				common[b] = 1'b0;
				for (int k = 0; k < VERTICES; k++)
					if (common[k])
						total += $countones(common & hood(k, c) & higher(k));
			end
			default: ;
		endcase
		r.count = total[CNT_W-1:0];
		r.mode  = m;
		return r;
	endfunction

	// Monitor: predicts at every input transfer, checks at every output transfer,
	// and runs the watchdog on cycles that carry no transfer at all.
	initial begin
		int      quiet;
		answer_t got;
		answer_t want;
		row_t    row;
		quiet = 0;
		errors = 0;
		answers_seen = 0;
		for (int v = 0; v < VERTICES; v++)
			edge_rows[v] = '0;
		forever begin
			@(posedge clk);
			quiet++;
			if (arst_n && in_valid && !in_stall) begin
				quiet = 0;
				row = typed_rows.pop_front();
				want = predict_clique_answer(mode, int'(vertex_a), int'(vertex_b), color);
				if (row.known)
					want.count = row.count;
				pending_answers.push_back(want);
			end
			if (arst_n && out_valid && !out_stall) begin
				quiet = 0;
				answers_seen++;
				got.count = clique_count;
				got.mode  = answered_mode;
				if (pending_answers.size() == 0) begin
					$error("unexpected result: clique_count %0d answered_mode %0d",
						got.count, got.mode);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (got.count !== want.count) begin
						$error("clique_count: expected %0d, actual %0d",
							want.count, got.count);
						errors++;
					end
					if (got.mode !== want.mode) begin
						$error("answered_mode: expected %0d, actual %0d",
							want.mode, got.mode);
						errors++;
					end
				end
			end
			if (quiet >= IDLE_LIMIT) begin
				$display("mono_k4_clique_counter_unit_tb NOT OK");
				$finish;
			end
		end
	end

	// Receiver: short random stalls, one long hold-off so that the block backs
	// up into its input, and no stalls at all once the run turns calm.
	initial begin
		int  stall_left;
		bit  long_done;
		stall_left = 0;
		long_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!long_done && answers_seen >= 30) begin
				long_done = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one item and holds it until the transfer happens.
	task automatic offer_item(input row_t row);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		typed_rows.push_back(row);
		in_valid <= 1'b1;
		mode     <= row.mode;
		vertex_a <= row.a;
		vertex_b <= row.b;
		color    <= row.c;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Random vertices cluster in two small groups so that pair queries in
	// color 1 find real cliques; some spread over the whole range.
	function automatic logic [V_BITS-1:0] pick_vertex();
		int r;
		r = $urandom_range(0, 7);
		if (r < 5)
			return V_BITS'($urandom_range(0, 7));
		else if (r == 5)
			return V_BITS'($urandom_range(120, 127));
		return V_BITS'($urandom_range(0, 127));
	endfunction

	row_t directed [21] = '{
		// Untouched graph is all color 0: every 4-set counts, C(128,4).
		'{MODE_ALL,   7'd0,   7'd0,   1'b0, 1'b1, 24'd10668000},
		// Pairs among the 126 other vertices, C(126,2).
		'{MODE_PAIR,  7'd0,   7'd1,   1'b0, 1'b1, 24'd7875},
		'{MODE_PAIR,  7'd0,   7'd0,   1'b1, 1'b1, 24'd0},
		'{MODE_NONE,  7'd127, 7'd127, 1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd0,   7'd1,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd0,   7'd2,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd0,   7'd3,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd1,   7'd2,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd1,   7'd3,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd3,   7'd2,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd5,   7'd5,   1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd127, 7'd126, 1'b1, 1'b1, 24'd0},
		'{MODE_WRITE, 7'd64,  7'd0,   1'b1, 1'b1, 24'd0},
		'{MODE_PAIR,  7'd0,   7'd1,   1'b1, 1'b0, 24'd0},
		'{MODE_PAIR,  7'd2,   7'd3,   1'b1, 1'b0, 24'd0},
		'{MODE_PAIR,  7'd127, 7'd127, 1'b1, 1'b0, 24'd0},
		'{MODE_PAIR,  7'd5,   7'd5,   1'b0, 1'b0, 24'd0},
		'{MODE_ALL,   7'd127, 7'd64,  1'b1, 1'b0, 24'd0},
		'{MODE_WRITE, 7'd3,   7'd0,   1'b0, 1'b1, 24'd0},
		'{MODE_PAIR,  7'd0,   7'd1,   1'b0, 1'b0, 24'd0},
		'{MODE_PAIR,  7'd1,   7'd2,   1'b1, 1'b0, 24'd0}
	};

	// Sender: reset, the directed table, then random traffic. Halfway through
	// it pauses until every answer is back; the tail runs without idling.
	initial begin
		row_t row;
		int   pick;
		calm        = 1'b0;
		sender_done = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		mode     = MODE_WRITE;
		vertex_a = '0;
		vertex_b = '0;
		color    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_item(directed[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				// The monitor books the last transfer before the queue is checked.
				@(posedge clk);
				while (pending_answers.size() != 0) @(posedge clk);
			end
			if (n == N_RANDOM - CALM_TAIL)
				calm = 1'b1;
			pick = $urandom_range(0, 9);
			row.mode  = (pick < 6) ? MODE_WRITE : (pick < 9) ? MODE_PAIR : MODE_NONE;
			row.a     = pick_vertex();
			row.b     = pick_vertex();
			row.c     = (row.mode == MODE_WRITE) ? ($urandom_range(0, 3) != 0)
				: 1'($urandom_range(0, 1));
			row.known = 1'b0;
			row.count = '0;
			offer_item(row);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("mono_k4_clique_counter_unit_tb OK");
		else
			$display("mono_k4_clique_counter_unit_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
design/kcc_pkg.sv
design/kcc_row_mem.sv
design/mono_k4_clique_counter_unit.sv
sim/mono_k4_clique_counter_unit_tb.sv
